>>> design/uks_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the unique key stack: sizes, state and result codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
package uks_pkg;

    // Stack geometry.
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 5;

    // Operation codes on the input channel.
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_RESULT
    } uks_state_t;

    // Kind of result to be reported.
    typedef enum logic [2:0] {
        RES_PUSHED,
        RES_DUP,
        RES_FULL,
        RES_REMOVED,
        RES_MISS
    } uks_res_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          start;
        logic          search_step;
        logic          hit;
        logic          shift_step;
        logic          push_write;
        logic          dec_count;
        logic          res_load;
        uks_res_kind_t res_kind;
    } uks_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_remove;
        logic match;
        logic search_done;
        logic shift_done;
        logic full;
        logic out_free;
    } uks_status_t;

endpackage

>>> design/uks_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the unique key stack: sequences search, gap
// closing, push and result hand-off. Depends on uks_pkg.
module uks_ctrl import uks_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  uks_status_t status,
    output uks_cmd_t    cmd
);

    uks_state_t    state_reg, state_next;
    uks_res_kind_t kind_reg, kind_next;

    // State and pending result kind.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= RES_MISS;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.res_kind = kind_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (status.match) begin
                    // Topmost match found; a remove goes on to close the gap.
                    cmd.hit = 1'b1;
                    if (status.is_remove) begin
                        state_next = ST_SHIFT;
                    end else begin
                        kind_next  = RES_DUP;
                        state_next = ST_RESULT;
                    end
                end else if (status.search_done) begin
                    state_next = ST_RESULT;
                    if (status.is_remove) begin
                        kind_next = RES_MISS;
                    end else if (status.full) begin
                        kind_next = RES_FULL;
                    end else begin
                        cmd.push_write = 1'b1;
                        kind_next      = RES_PUSHED;
                    end
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (status.shift_done) begin
                    cmd.dec_count = 1'b1;
                    kind_next     = RES_REMOVED;
                    state_next    = ST_RESULT;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/uks_datapath.sv
`timescale 1ns / 1ps
// Datapath of the unique key stack: entry storage with a registered read
// port, search and shift pointers, entry count and the result register.
// Depends on uks_pkg.
module uks_datapath import uks_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_operation,
    input  logic signed [31:0]   s_serial_number,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COUNT_W-1:0]   m_count_value,
    output logic                 m_found,
    output logic                 m_full_res,
    input  uks_cmd_t             cmd,
    output uks_status_t          status
);

    logic [KEY_W-1:0]  stack_reg [DEPTH];
    logic [KEY_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rda_reg;
    logic              rdv_reg, rdv_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              m_valid_reg;
    logic [COUNT_W-1:0] count_value_reg;
    logic              found_reg;
    logic              full_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic [CNT_W-1:0]  res_count;

    // Read port: search walks down from the top, the shift walks up.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg[ADDR_W-1:0];
        if (cmd.search_step && (ptr_reg != '0)) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(ptr_reg - CNT_W'(1));
        end else if (cmd.shift_step && (ptr_reg < count_reg)) begin
            rd_en   = 1'b1;
            rd_addr = ptr_reg[ADDR_W-1:0];
        end
    end

    // Write port: a push places the key on top, a shift moves an entry down.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = key_reg;
        if (cmd.push_write) begin
            wr_en = 1'b1;
        end else if (cmd.shift_step && rdv_reg) begin
            wr_en   = 1'b1;
            wr_addr = rda_reg - ADDR_W'(1);
            wr_data = rd_data_reg;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_reg[rd_addr];
            rda_reg     <= rd_addr;
        end
    end

    // Pointer, read-valid flag and entry count.
    always_comb begin
        ptr_next   = ptr_reg;
        rdv_next   = rdv_reg;
        count_next = count_reg;
        if (cmd.start) begin
            ptr_next = count_reg;
            rdv_next = 1'b0;
        end else if (cmd.hit) begin
            ptr_next = CNT_W'(rda_reg) + CNT_W'(1);
            rdv_next = 1'b0;
        end else if (cmd.search_step) begin
            rdv_next = rd_en;
            if (rd_en) begin
                ptr_next = ptr_reg - CNT_W'(1);
            end
        end else if (cmd.shift_step) begin
            rdv_next = rd_en;
            if (rd_en) begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
        end
        if (cmd.push_write) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.dec_count) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            rdv_reg   <= 1'b0;
            count_reg <= '0;
        end else begin
            ptr_reg   <= ptr_next;
            rdv_reg   <= rdv_next;
            count_reg <= count_next;
        end
    end

    // Transaction payload and hit position.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= s_operation;
            key_reg <= s_serial_number;
        end
        if (cmd.hit) begin
            pos_reg <= rda_reg;
        end
    end

    // Result value: entries above the duplicate, or the current count.
    assign res_count = (cmd.res_kind == RES_DUP)
                     ? (count_reg - CNT_W'(1) - CNT_W'(pos_reg))
                     : count_reg;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            count_value_reg <= COUNT_W'(res_count);
            found_reg       <= (cmd.res_kind inside {RES_DUP, RES_REMOVED});
            full_reg        <= (cmd.res_kind == RES_FULL);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_count_value = count_value_reg;
    assign m_found       = found_reg;
    assign m_full_res    = full_reg;

    // Status towards the controller.
    always_comb begin
        status             = '0;
        status.is_remove   = (op_reg == OP_REMOVE);
        status.match       = rdv_reg && (rd_data_reg == key_reg);
        status.search_done = (ptr_reg == '0) && !rdv_reg;
        status.shift_done  = (ptr_reg >= count_reg) && !rdv_reg;
        status.full        = (count_reg == CNT_W'(DEPTH));
        status.out_free    = !m_valid_reg || m_ready;
    end

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // A push only writes into a free slot.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_write |-> (count_reg < CNT_W'(DEPTH)))
        else $error("push into a full stack");

    // A shift only moves entries that lie inside the stack.
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_step && rdv_reg) |-> (CNT_W'(rda_reg) < count_reg && rda_reg != '0))
        else $error("shift outside the valid entries");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // A remove that deletes an entry lowers the count by one.
    a_dec_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dec_count |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count not decremented after removal");

endmodule

>>> design/unique_key_stack.sv
`timescale 1ns / 1ps
// Unique key stack: a bounded stack of 32-bit keys, newest on top, that
// refuses duplicate pushes and removes keys while keeping order. It holds at
// most 16 entries. The search reads one entry per cycle from the top through
// the storage's single registered read port, and closing the gap after a
// removal moves one entry per cycle through the same port. One transaction
// is worked on at a time; a new one is taken as soon as the previous result
// sits in the output register. The stack is empty after reset. Depends on
// uks_pkg, uks_ctrl and uks_datapath.
module unique_key_stack import uks_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic signed [31:0]   s_serial_number,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COUNT_W-1:0]   m_count_value,
    output logic                 m_found,
    output logic                 m_full_res
);

    uks_cmd_t    cmd;
    uks_status_t status;

    // Controller.
    uks_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath.
    uks_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_operation     (s_operation),
        .s_serial_number (s_serial_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_count_value   (m_count_value),
        .m_found         (m_found),
        .m_full_res      (m_full_res),
        .cmd             (cmd),
        .status          (status)
    );

endmodule
